// ----- rtl/selt_pkg.sv -----
`timescale 1ns / 1ps

package selt_pkg;

  typedef enum logic [1:0] {
    ACT_SHARED = 2'd0,
    ACT_EXCL   = 2'd1,
    ACT_UNLOCK = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_GRANTED   = 3'd0,
    ST_CONFLICT  = 3'd1,
    ST_FULL      = 3'd2,
    ST_RELEASED  = 3'd3,
    ST_SATURATED = 3'd4
  } status_e;

  localparam int unsigned ValueW = 8;

  localparam logic signed [ValueW-1:0] ValExcl = -8'sd1;
  localparam logic signed [ValueW-1:0] ValFree = 8'sd0;
  localparam logic signed [ValueW-1:0] ValOne  = 8'sd1;

  // Table update decided for one request.
  typedef struct packed {
    logic                       write;   // overwrite the value of the hit entry
    logic                       alloc;   // fill the lowest free slot
    logic                       drop;    // free the hit entry
    logic signed [ValueW-1:0]   value;
    status_e                    status;
  } upd_t;

endpackage

// ----- rtl/selt_match.sv -----
`timescale 1ns / 1ps

module selt_match #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic [ENTRIES-1:0]                 valid_i,
  input  logic [15:0]                        file_i  [ENTRIES],
  input  logic [31:0]                        block_i [ENTRIES],
  input  logic signed [selt_pkg::ValueW-1:0] count_i [ENTRIES],
  input  logic [15:0]                        key_file_i,
  input  logic [31:0]                        key_block_i,
  output logic [ENTRIES-1:0]                 match_o,
  output logic [ENTRIES-1:0]                 free_oh_o,
  output logic                               hit_o,
  output logic                               any_free_o,
  output logic signed [selt_pkg::ValueW-1:0] count_o
);
  import selt_pkg::*;

  logic [ENTRIES-1:0] free_vec;
  logic [ENTRIES-1:0] match;

  // Keys are unique in the table, so at most one entry matches.
  always_comb begin
    match   = '0;
    count_o = ValFree;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_i[i] && (file_i[i] == key_file_i) && (block_i[i] == key_block_i);
      count_o  = count_o | ({ValueW{match[i]}} & count_i[i]);
    end
  end

  assign match_o    = match;
  assign hit_o      = |match;
  assign free_vec   = ~valid_i;
  // Isolate the lowest set bit: the lowest-numbered free slot.
  assign free_oh_o  = free_vec & (~free_vec + ENTRIES'(1));
  assign any_free_o = |free_vec;

endmodule

// ----- rtl/selt_decide.sv -----
`timescale 1ns / 1ps

module selt_decide #(
  parameter int unsigned MAX_SHARED = 127
) (
  input  logic [1:0]                         action_i,
  input  logic                               hit_i,
  input  logic                               any_free_i,
  input  logic signed [selt_pkg::ValueW-1:0] count_i,
  output selt_pkg::upd_t                     upd_o
);
  import selt_pkg::*;

  localparam logic signed [ValueW-1:0] MaxCount = ValueW'(MAX_SHARED);

  logic signed [ValueW-1:0] cur;
  logic                     excl;

  assign cur  = hit_i ? count_i : ValFree;
  assign excl = (action_i == ACT_EXCL);

  always_comb begin
    upd_o         = '0;
    upd_o.value   = cur;
    upd_o.status  = ST_CONFLICT;
    unique case (action_e'(action_i))
      ACT_SHARED, ACT_EXCL: begin
        if (hit_i) begin
          priority if (!excl && cur < 0) begin
            upd_o.status = ST_CONFLICT;
          end else if (!excl && cur >= MaxCount) begin
            upd_o.status = ST_SATURATED;
          end else if (excl && cur > ValOne) begin
            upd_o.status = ST_CONFLICT;
          end else begin
            upd_o.write  = 1'b1;
            upd_o.value  = excl ? ValExcl : ValueW'(cur + ValOne);
            upd_o.status = ST_GRANTED;
          end
        end else if (!any_free_i) begin
          upd_o.status = ST_FULL;
          upd_o.value  = ValFree;
        end else begin
          upd_o.alloc  = 1'b1;
          upd_o.value  = excl ? ValExcl : ValOne;
          upd_o.status = ST_GRANTED;
        end
      end
      ACT_UNLOCK: begin
        upd_o.status = ST_RELEASED;
        if (hit_i && cur > ValOne) begin
          upd_o.write = 1'b1;
          upd_o.value = ValueW'(cur - ValOne);
        end else begin
          upd_o.drop  = hit_i;
          upd_o.value = ValFree;
        end
      end
      default: begin
        upd_o.status = ST_CONFLICT;
        upd_o.value  = cur;
      end
    endcase
  end

endmodule

// ----- rtl/shared_exclusive_lock_table.sv -----
// Shared/exclusive lock table, one request per transfer on start_i.
// Result: done_o comes from the result register, which follows the input register and the table lookup.
// Throughput: one request every cycle; busy_o stays low, the table compare and update happen in the same cycle.
// Reset (rst_ni low, asynchronous) empties the table and drops any request in flight.
// The receiver cannot stall: done_o, status_o and lock_value_o are valid for one cycle.
`timescale 1ns / 1ps

module shared_exclusive_lock_table #(
  parameter int unsigned TABLE_ENTRIES = 16,
  parameter int unsigned MAX_SHARED    = 127
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [1:0]                         action_i,
  input  logic [15:0]                        file_id_i,
  input  logic [31:0]                        block_number_i,
  output logic                               done_o,
  output logic [2:0]                         status_o,
  output logic signed [selt_pkg::ValueW-1:0] lock_value_o
);
  import selt_pkg::*;

  // The request is first captured in an input register. In the next cycle the
  // key is compared against every table entry at once, the decision logic
  // picks the update, and both the table and the result register are written
  // at the same edge. A request in the following cycle therefore always sees
  // the table as left by the one before it, so no hazard logic is needed.

  // Input register.
  logic        req_vld_q;
  logic [1:0]  req_act_q;
  logic [15:0] req_file_q;
  logic [31:0] req_block_q;

  // Table storage. Only the valid bits are reset; the key and count of an
  // entry are read only while its valid bit is set.
  logic [TABLE_ENTRIES-1:0]   valid_q;
  logic [TABLE_ENTRIES-1:0]   valid_d;
  logic [15:0]                file_q  [TABLE_ENTRIES];
  logic [31:0]                block_q [TABLE_ENTRIES];
  logic signed [ValueW-1:0]   count_q [TABLE_ENTRIES];

  // Result register.
  logic                     done_q;
  logic [2:0]               status_q;
  logic signed [ValueW-1:0] value_q;

  // Lookup and decision.
  logic [TABLE_ENTRIES-1:0] match;
  logic [TABLE_ENTRIES-1:0] free_oh;
  logic                     hit;
  logic                     any_free;
  logic signed [ValueW-1:0] hit_count;
  upd_t                     upd;

  // Every cycle can take a request.
  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else begin
      req_vld_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      req_act_q   <= action_i;
      req_file_q  <= file_id_i;
      req_block_q <= block_number_i;
    end
  end

  selt_match #(
    .ENTRIES (TABLE_ENTRIES)
  ) u_match (
    .valid_i     (valid_q),
    .file_i      (file_q),
    .block_i     (block_q),
    .count_i     (count_q),
    .key_file_i  (req_file_q),
    .key_block_i (req_block_q),
    .match_o     (match),
    .free_oh_o   (free_oh),
    .hit_o       (hit),
    .any_free_o  (any_free),
    .count_o     (hit_count)
  );

  selt_decide #(
    .MAX_SHARED (MAX_SHARED)
  ) u_decide (
    .action_i   (req_act_q),
    .hit_i      (hit),
    .any_free_i (any_free),
    .count_i    (hit_count),
    .upd_o      (upd)
  );

  // A new entry takes the lowest free slot; an unlock that frees an entry
  // clears the valid bit of the matching one.
  always_comb begin
    valid_d = valid_q;
    if (req_vld_q) begin
      if (upd.alloc) begin
        valid_d = valid_q | free_oh;
      end else if (upd.drop) begin
        valid_d = valid_q & ~match;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (req_vld_q && upd.alloc && free_oh[i]) begin
        file_q[i]  <= req_file_q;
        block_q[i] <= req_block_q;
        count_q[i] <= upd.value;
      end else if (req_vld_q && upd.write && match[i]) begin
        count_q[i] <= upd.value;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= req_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_vld_q) begin
      status_q <= upd.status;
      value_q  <= upd.value;
    end
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign lock_value_o = value_q;

endmodule

// ----- rtl/selt_checker.sv -----
`timescale 1ns / 1ps

module selt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic [1:0]  action_i,
  input logic        done_o,
  input logic [2:0]  status_o,
  input logic [7:0]  lock_value_o
);
  import selt_pkg::*;

  // Every accepted request is answered on done_o, through the input and result registers.
  a_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##2 done_o)
    else $error("accepted request not answered after two cycles");

  // No answer appears without an accepted request before it.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 2))
    else $error("answer without a matching request");

  // A granted exclusive lock always leaves the block held exclusively.
  a_excl_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_GRANTED && $past(action_i, 2) == ACT_EXCL)
      |-> lock_value_o == ValExcl)
    else $error("granted exclusive lock with wrong value");

  // Full table and unlock never report an exclusive holder.
  a_full_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_FULL || status_o == ST_RELEASED)) |-> !lock_value_o[7])
    else $error("negative value reported for full or released");

endmodule

bind shared_exclusive_lock_table selt_checker u_selt_checker (.*);
